### rtl/gcd_pkg.sv
// Package for the great-circle distance pipeline: widths, fixed-point
// constants, stage counts and the CORDIC arctangent table.
// No dependencies.
package gcd_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int N_STEPS      = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    localparam int W_LAT    = 24;
    localparam int W_LON    = 25;
    localparam int W_DIST   = 23;
    localparam int W_ROT    = 34;   // rotation CORDIC x, y, z (Q30)
    localparam int W_VEC    = 36;   // vectoring CORDIC x, y (Q31)
    localparam int W_SQ_IN  = 64;
    localparam int W_SQ_OUT = 32;
    localparam int N_LANES  = 3;    // lat a, lat b, longitude difference

    localparam logic signed [27:0] DEG90  = 28'sd5898240;
    localparam logic signed [27:0] DEG180 = 28'sd11796480;
    localparam logic signed [27:0] DEG360 = 28'sd23592960;

    localparam logic signed [27:0]       TO_RAD_Q32   = 28'sd74961321;
    localparam logic signed [W_ROT-1:0]  INV_GAIN_Q30 = W_ROT'(652032874);
    localparam logic [15:0]              DIAM_KM      = 16'd12742;
    localparam logic [W_DIST-1:0]        DIST_MAX     = W_DIST'(5124000);

    typedef logic signed [W_ROT-1:0] t_rot;
    typedef logic signed [W_VEC-1:0] t_vec;

    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            24: v = 32'h0000003F;
            25: v = 32'h0000001F;
            26: v = 32'h0000000F;
            27: v = 32'h00000008;
            28: v = 32'h00000004;
            29: v = 32'h00000002;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

### rtl/gcd_in_if.sv
// Request channel of the distance block: two points, valid/ready.
// Depends on gcd_pkg.
interface gcd_in_if;
    import gcd_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [W_LAT-1:0] lat_a;
    logic signed [W_LON-1:0] lon_a;
    logic signed [W_LAT-1:0] lat_b;
    logic signed [W_LON-1:0] lon_b;

    modport source (output valid, lat_a, lon_a, lat_b, lon_b, input ready);
    modport sink   (input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

### rtl/gcd_out_if.sv
// Result channel of the distance block: distance in km Q8, valid/ready.
// Depends on gcd_pkg.
interface gcd_out_if;
    import gcd_pkg::*;
    logic              valid;
    logic              ready;
    logic [W_DIST-1:0] distance_km;

    modport source (output valid, distance_km, input ready);
    modport sink   (input valid, distance_km, output ready);
endinterface

### rtl/gcd_front.sv
// Front end: latitude clamp, longitude difference wrap and fold, then
// degrees to radians (Q30). Two register stages. Depends on gcd_pkg.
module gcd_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic signed [gcd_pkg::W_LAT-1:0] i_lat_a,
    input  logic signed [gcd_pkg::W_LON-1:0] i_lon_a,
    input  logic signed [gcd_pkg::W_LAT-1:0] i_lat_b,
    input  logic signed [gcd_pkg::W_LON-1:0] i_lon_b,
    output logic                             o_valid,
    output gcd_pkg::t_rot                    o_ang [gcd_pkg::N_LANES],
    output logic                             o_neg
);
    import gcd_pkg::*;

    logic signed [27:0] d_raw, d_wrap, d_fold;
    logic signed [27:0] la_ext, lb_ext;
    logic               neg;
    logic signed [23:0] n_la, n_lb, n_d;

    logic               r_v1, r_v2, r_neg1, r_neg2;
    logic signed [23:0] r_deg [N_LANES];
    t_rot               r_ang [N_LANES];

    always_comb begin
        d_raw  = 28'(i_lon_a) - 28'(i_lon_b) + DEG180;
        if (d_raw < 0) begin
            d_wrap = d_raw + DEG360;
        end else if (d_raw >= DEG360) begin
            d_wrap = d_raw - DEG360;
        end else begin
            d_wrap = d_raw;
        end
        d_wrap = d_wrap - DEG180;
        neg = 1'b0;
        if (d_wrap > DEG90) begin
            d_fold = d_wrap - DEG180;
            neg    = 1'b1;
        end else if (d_wrap < -DEG90) begin
            d_fold = d_wrap + DEG180;
            neg    = 1'b1;
        end else begin
            d_fold = d_wrap;
        end
        la_ext = 28'(i_lat_a);
        lb_ext = 28'(i_lat_b);
        n_la = 24'((la_ext > DEG90) ? DEG90 : ((la_ext < -DEG90) ? -DEG90 : la_ext));
        n_lb = 24'((lb_ext > DEG90) ? DEG90 : ((lb_ext < -DEG90) ? -DEG90 : lb_ext));
        n_d  = 24'(d_fold);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_deg[0] <= n_la;
            r_deg[1] <= n_lb;
            r_deg[2] <= n_d;
            r_neg1   <= neg;
            r_neg2   <= r_neg1;
        end
    end

    // Q16 * Q32 = Q48, rounded to Q30
    for (genvar l = 0; l < N_LANES; l++) begin : g_rad
        logic signed [51:0] prod, rnd;
        assign prod = 52'(r_deg[l]) * 52'(TO_RAD_Q32);
        assign rnd  = prod + (52'sd1 <<< 17);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ang[l] <= $signed(rnd[18+W_ROT-1:18]);
            end
        end
        assign o_ang[l] = r_ang[l];
    end

    assign o_valid = r_v2;
    assign o_neg   = r_neg2;

    a_lon_folded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (28'(r_deg[2]) <= DEG90) && (28'(r_deg[2]) >= -DEG90))
        else $error("longitude difference not folded into +-90 degrees");
    a_lat_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (28'(r_deg[0]) <= DEG90) && (28'(r_deg[0]) >= -DEG90)
              && (28'(r_deg[1]) <= DEG90) && (28'(r_deg[1]) >= -DEG90))
        else $error("latitude escaped clamp");
endmodule

### rtl/gcd_rot.sv
// Rotation-mode CORDIC, one register stage per iteration, three lanes
// side by side giving sine and cosine (Q30). Depends on gcd_pkg.
module gcd_rot (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  gcd_pkg::t_rot i_ang [gcd_pkg::N_LANES],
    input  logic          i_neg,
    output logic          o_valid,
    output gcd_pkg::t_rot o_sin [gcd_pkg::N_LANES],
    output gcd_pkg::t_rot o_cos [gcd_pkg::N_LANES],
    output logic          o_neg
);
    import gcd_pkg::*;

    t_rot s_x [N_STEPS+1][N_LANES];
    t_rot s_y [N_STEPS+1][N_LANES];
    t_rot s_z [N_STEPS+1][N_LANES];
    logic s_v   [N_STEPS+1];
    logic s_neg [N_STEPS+1];

    assign s_v[0]   = i_valid;
    assign s_neg[0] = i_neg;
    for (genvar l = 0; l < N_LANES; l++) begin : g_init
        assign s_x[0][l] = INV_GAIN_Q30;
        assign s_y[0][l] = '0;
        assign s_z[0][l] = i_ang[l];
    end

    for (genvar i = 0; i < N_STEPS; i++) begin : g_step
        localparam t_rot ATAN = $signed(W_ROT'(atan_q30(i)));
        logic r_v, r_neg;
        t_rot r_x [N_LANES];
        t_rot r_y [N_LANES];
        t_rot r_z [N_LANES];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= s_v[i];
            end
        end

        for (genvar l = 0; l < N_LANES; l++) begin : g_lane
            logic pos;
            assign pos = !s_z[i][l][W_ROT-1];
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[l] <= pos ? s_x[i][l] - (s_y[i][l] >>> i)
                                  : s_x[i][l] + (s_y[i][l] >>> i);
                    r_y[l] <= pos ? s_y[i][l] + (s_x[i][l] >>> i)
                                  : s_y[i][l] - (s_x[i][l] >>> i);
                    r_z[l] <= pos ? s_z[i][l] - ATAN : s_z[i][l] + ATAN;
                end
            end
            assign s_x[i+1][l] = r_x[l];
            assign s_y[i+1][l] = r_y[l];
            assign s_z[i+1][l] = r_z[l];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg <= s_neg[i];
            end
        end
        assign s_v[i+1]   = r_v;
        assign s_neg[i+1] = r_neg;
    end

    for (genvar l = 0; l < N_LANES; l++) begin : g_out
        assign o_sin[l] = s_y[N_STEPS][l];
        assign o_cos[l] = s_x[N_STEPS][l];
    end
    assign o_valid = s_v[N_STEPS];
    assign o_neg   = s_neg[N_STEPS];
endmodule

### rtl/gcd_chord.sv
// Chord vector between the two unit vectors and its squared length (Q60).
// Three register stages: chord components, squares, sum. Depends on gcd_pkg.
module gcd_chord (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  gcd_pkg::t_rot                 i_sin [gcd_pkg::N_LANES],
    input  gcd_pkg::t_rot                 i_cos [gcd_pkg::N_LANES],
    input  logic                          i_neg,
    output logic                          o_valid,
    output logic [gcd_pkg::W_SQ_IN-1:0]   o_sum
);
    import gcd_pkg::*;

    t_rot               sp, cp;
    logic signed [63:0] m_x, m_y, q_x, q_y;
    logic signed [32:0] n_d [3];

    logic               r_v1, r_v2, r_v3;
    logic signed [32:0] r_d  [3];
    logic [63:0]        r_sq [3];
    logic [63:0]        r_sum;

    always_comb begin
        sp  = i_neg ? -i_sin[2] : i_sin[2];
        cp  = i_neg ? -i_cos[2] : i_cos[2];
        m_x = 64'($signed(cp[31:0])) * 64'($signed(i_cos[0][31:0]));
        m_y = 64'($signed(sp[31:0])) * 64'($signed(i_cos[0][31:0]));
        q_x = (m_x + (64'sd1 <<< 29)) >>> 30;
        q_y = (m_y + (64'sd1 <<< 29)) >>> 30;
        n_d[0] = 33'(q_x - 64'(i_cos[1]));
        n_d[1] = 33'(q_y);
        n_d[2] = 33'(i_sin[0] - i_sin[1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_sq
        logic signed [65:0] sq;
        assign sq = 66'(r_d[k]) * 66'(r_d[k]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d[k]  <= n_d[k];
                r_sq[k] <= sq[63:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

    assign o_valid = r_v3;
    assign o_sum   = r_sum;
endmodule

### rtl/gcd_isqrt.sv
// Pipelined floor square root, one result bit per register stage, with
// a side word carried alongside. Depends on gcd_pkg.
module gcd_isqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [gcd_pkg::W_SQ_IN-1:0]  i_n,
    input  logic [gcd_pkg::W_SQ_OUT-1:0] i_side,
    output logic                         o_valid,
    output logic [gcd_pkg::W_SQ_OUT-1:0] o_root,
    output logic [gcd_pkg::W_SQ_OUT-1:0] o_side
);
    import gcd_pkg::*;

    localparam int NB = W_SQ_OUT;
    localparam int WT = W_SQ_IN + 2;

    logic [W_SQ_IN-1:0] s_rem  [NB+1];
    logic [NB-1:0]      s_r    [NB+1];
    logic [NB-1:0]      s_side [NB+1];
    logic               s_v    [NB+1];

    assign s_rem[0]  = i_n;
    assign s_r[0]    = '0;
    assign s_side[0] = i_side;
    assign s_v[0]    = i_valid;

    for (genvar j = 0; j < NB; j++) begin : g_bit
        localparam int K = NB - 1 - j;
        logic [WT-1:0]      trial;
        logic               take;
        logic               r_v;
        logic [W_SQ_IN-1:0] r_rem;
        logic [NB-1:0]      r_r, r_side;

        // (r + 2^K)^2 - r^2 = r*2^(K+1) + 2^(2K)
        assign trial = (WT'(s_r[j]) << (K + 1)) + (WT'(1) << (2 * K));
        assign take  = WT'(s_rem[j]) >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= s_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= take ? W_SQ_IN'(WT'(s_rem[j]) - trial) : s_rem[j];
                r_r    <= take ? (s_r[j] | (NB'(1) << K)) : s_r[j];
                r_side <= s_side[j];
            end
        end

        assign s_v[j+1]    = r_v;
        assign s_rem[j+1]  = r_rem;
        assign s_r[j+1]    = r_r;
        assign s_side[j+1] = r_side;
    end

    assign o_valid = s_v[NB];
    assign o_root  = s_r[NB];
    assign o_side  = s_side[NB];
endmodule

### rtl/gcd_hsq.sv
// Half-chord clamp to one (Q31) and 2^62 - h^2 for the cosine side.
// Two register stages. Depends on gcd_pkg.
module gcd_hsq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [gcd_pkg::W_SQ_OUT-1:0] i_h,
    output logic                         o_valid,
    output logic [gcd_pkg::W_SQ_IN-1:0]  o_gg,
    output logic [gcd_pkg::W_SQ_OUT-1:0] o_h
);
    import gcd_pkg::*;

    localparam logic [W_SQ_OUT-1:0] ONE_Q31 = W_SQ_OUT'(1) << 31;

    logic [W_SQ_OUT-1:0] hc;
    logic                r_v1, r_v2;
    logic [W_SQ_OUT-1:0] r_h1, r_h2;
    logic [W_SQ_IN-1:0]  r_hh, r_gg;

    assign hc = (i_h > ONE_Q31) ? ONE_Q31 : i_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h1 <= hc;
            r_hh <= W_SQ_IN'(hc) * W_SQ_IN'(hc);
            r_h2 <= r_h1;
            r_gg <= (W_SQ_IN'(1) << 62) - r_hh;
        end
    end

    assign o_valid = r_v2;
    assign o_gg    = r_gg;
    assign o_h     = r_h2;
endmodule

### rtl/gcd_arc.sv
// Vectoring-mode CORDIC for the arc angle, one stage per iteration, then
// scaling by the diameter with rounding and saturation. Depends on gcd_pkg.
module gcd_arc (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [gcd_pkg::W_SQ_OUT-1:0] i_h,
    input  logic [gcd_pkg::W_SQ_OUT-1:0] i_g,
    output logic                         o_valid,
    output logic [gcd_pkg::W_DIST-1:0]   o_dist
);
    import gcd_pkg::*;

    t_vec s_x [N_STEPS+1];
    t_vec s_y [N_STEPS+1];
    t_rot s_z [N_STEPS+1];
    logic s_v [N_STEPS+1];

    assign s_x[0] = $signed(W_VEC'(i_g));
    assign s_y[0] = $signed(W_VEC'(i_h));
    assign s_z[0] = '0;
    assign s_v[0] = i_valid;

    for (genvar i = 0; i < N_STEPS; i++) begin : g_step
        localparam t_rot ATAN = $signed(W_ROT'(atan_q30(i)));
        logic pos, r_v;
        t_vec r_x, r_y;
        t_rot r_z;

        assign pos = s_y[i] > 0;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= s_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x <= pos ? s_x[i] + (s_y[i] >>> i) : s_x[i] - (s_y[i] >>> i);
                r_y <= pos ? s_y[i] - (s_x[i] >>> i) : s_y[i] + (s_x[i] >>> i);
                r_z <= pos ? s_z[i] + ATAN : s_z[i] - ATAN;
            end
        end

        assign s_v[i+1] = r_v;
        assign s_x[i+1] = r_x;
        assign s_y[i+1] = r_y;
        assign s_z[i+1] = r_z;
    end

    // arc Q30 * 12742 km, rounded to Q8; a slightly negative arc gives zero
    logic [W_ROT-1:0]  zc;
    logic [47:0]       prod, scaled;
    logic              r_v;
    logic [W_DIST-1:0] r_dist;

    assign zc     = s_z[N_STEPS][W_ROT-1] ? '0 : W_ROT'(s_z[N_STEPS]);
    assign prod   = 48'(zc) * 48'(DIAM_KM) + (48'd1 << 21);
    assign scaled = prod >> 22;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= s_v[N_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dist <= (scaled > 48'(DIST_MAX)) ? DIST_MAX : W_DIST'(scaled);
        end
    end

    assign o_valid = r_v;
    assign o_dist  = r_dist;

    a_dist_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v |-> (r_dist <= DIST_MAX))
        else $error("distance above saturation limit");
endmodule

### rtl/great_circle_distance.sv
// Great-circle distance between two points, one request per cycle while o_res is not stalled.
//
// Request channel i_req: lat_a, lon_a, lat_b, lon_b in signed degrees Q16.
// Result channel o_res: distance_km, unsigned km Q8, one per request, in order.
// Latitudes beyond +-90 degrees are clamped; longitudes of any value are
// taken. The distance saturates at 5124000 (about 20015.6 km).
//
// Throughput: one request per cycle while o_res is not stalled. Pipeline:
// 2 front-end stages, N_STEPS sine/cosine stages, 3 chord stages, 32
// square root stages, 2 clamp stages, 32 more square root stages,
// N_STEPS arc stages and one scaling stage.
//
// Every stage advances together on a single enable. When o_res holds a result
// that is not taken, the whole pipe freezes and i_req.ready drops in the
// same cycle; nothing is lost or repeated. Reset (synchronous, active low)
// clears all stage valid bits; the pipe is empty and ready afterwards.
module great_circle_distance (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gcd_in_if.sink    i_req,
    gcd_out_if.source o_res
);
    import gcd_pkg::*;

    logic en;

    logic  f_v, f_neg;
    t_rot  f_ang [N_LANES];
    logic  r_vld, r_neg;
    t_rot  r_sin [N_LANES];
    t_rot  r_cos [N_LANES];
    logic  c_v;
    logic [W_SQ_IN-1:0]  c_sum;
    logic  s1_v;
    logic [W_SQ_OUT-1:0] s1_root;
    logic  h_v;
    logic [W_SQ_IN-1:0]  h_gg;
    logic [W_SQ_OUT-1:0] h_h;
    logic  s2_v;
    logic [W_SQ_OUT-1:0] s2_root, s2_h;

    assign en          = !o_res.valid || o_res.ready;
    assign i_req.ready = en;

    gcd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_req.valid),
        .i_lat_a (i_req.lat_a),
        .i_lon_a (i_req.lon_a),
        .i_lat_b (i_req.lat_b),
        .i_lon_b (i_req.lon_b),
        .o_valid (f_v),
        .o_ang   (f_ang),
        .o_neg   (f_neg)
    );

    gcd_rot u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_v),
        .i_ang   (f_ang),
        .i_neg   (f_neg),
        .o_valid (r_vld),
        .o_sin   (r_sin),
        .o_cos   (r_cos),
        .o_neg   (r_neg)
    );

    gcd_chord u_chord (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vld),
        .i_sin   (r_sin),
        .i_cos   (r_cos),
        .i_neg   (r_neg),
        .o_valid (c_v),
        .o_sum   (c_sum)
    );

    // chord length in Q30 is the half-chord in Q31
    gcd_isqrt u_sqrt_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (c_v),
        .i_n     (c_sum),
        .i_side  ('0),
        .o_valid (s1_v),
        .o_root  (s1_root),
        .o_side  ()
    );

    gcd_hsq u_hsq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s1_v),
        .i_h     (s1_root),
        .o_valid (h_v),
        .o_gg    (h_gg),
        .o_h     (h_h)
    );

    gcd_isqrt u_sqrt_g (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (h_v),
        .i_n     (h_gg),
        .i_side  (h_h),
        .o_valid (s2_v),
        .o_root  (s2_root),
        .o_side  (s2_h)
    );

    gcd_arc u_arc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s2_v),
        .i_h     (s2_h),
        .i_g     (s2_root),
        .o_valid (o_res.valid),
        .o_dist  (o_res.distance_km)
    );

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid straight after reset");
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |-> !i_req.ready)
        else $error("request taken while result stalled");
endmodule
